// ----- sv/fnpt_pkg.sv -----
`timescale 1ns / 1ps

package fnpt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_OUT = 32;
    localparam int LIST_W = $clog2(MAX_OUT + 1);
    localparam int COORD_W = 24;
    localparam int MAG_W = COORD_W + 1;
    localparam int SQ_W = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 2;

    typedef logic [2:0] mode_code_t;
    localparam mode_code_t MODE_UPSERT  = 3'd0;
    localparam mode_code_t MODE_REMOVE  = 3'd1;
    localparam mode_code_t MODE_GET     = 3'd2;
    localparam mode_code_t MODE_NEAREST = 3'd3;
    localparam mode_code_t MODE_COUNT   = 3'd4;
    localparam mode_code_t MODE_LIST    = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NOTFOUND = 2'd1;
    localparam status_t ST_FULL     = 2'd2;

    typedef struct packed {
        logic [31:0]             id;
        logic [15:0]             map;
        logic [15:0]             group;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [5:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+5:0] wide;
        wide = {6'b0, c};
        return (wide > (CNT_W + 6)'(63)) ? 6'd63 : wide[5:0];
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
        logic signed [MAG_W-1:0] d;
        logic [MAG_W-1:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
        return m * m;
    endfunction

endpackage

// ----- sv/fnpt_ram.sv -----
`timescale 1ns / 1ps

module fnpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/filtered_nearest_point_table_top.sv -----
`timescale 1ns / 1ps
// one transaction at a time; req_ready is high only while idle
// count and unused modes: the final step registers the result once the output slot is free
// get, upsert, remove, list: a read and a check step per entry (one ram read per entry);
// a get hit ends on the matching entry, an upsert hit goes straight to the final step
// nearest: squaring steps per map/group match; fetch of the best (if any) and the final step
// async active-low reset empties the table and clears control; table contents are not cleared

module filtered_nearest_point_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] point_id,
    input  logic [15:0] map_key,
    input  logic [15:0] group_key,
    input  logic signed [23:0] coord_x,
    input  logic signed [23:0] coord_y,
    input  logic signed [23:0] coord_z,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [31:0] found_id,
    output logic [15:0] found_map,
    output logic [15:0] found_group,
    output logic signed [23:0] found_x,
    output logic signed [23:0] found_y,
    output logic signed [23:0] found_z,
    output logic [5:0]  entry_count,
    output logic        last
);

    localparam int CNT_W = fnpt_pkg::CNT_W;
    localparam int IDX_W = fnpt_pkg::IDX_W;
    localparam int LIST_W = fnpt_pkg::LIST_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(fnpt_pkg::TABLE_DEPTH);
    localparam logic [LIST_W-1:0] MAX_OUT_C = LIST_W'(fnpt_pkg::MAX_OUT);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_SQ, S_FETCH, S_FIN} state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           held_reg, held_next;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           w_reg, w_next;
    logic [LIST_W-1:0]          n_reg, n_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       hit_reg, hit_next;
    logic                       best_valid_reg, best_valid_next;
    logic [CNT_W-1:0]           best_idx_reg, best_idx_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       out_valid_reg, out_valid_next;
    fnpt_pkg::status_t          out_status_reg, out_status_next;
    fnpt_pkg::entry_t           out_ent_reg, out_ent_next;
    logic [5:0]                 out_cnt_reg, out_cnt_next;
    logic                       out_last_reg, out_last_next;

    fnpt_pkg::mode_code_t       mode_reg;
    fnpt_pkg::entry_t           q_reg;
    fnpt_pkg::entry_t           pend_reg, pend_next;
    logic [fnpt_pkg::SQ_W-1:0]  prod_reg, prod_next;
    logic [fnpt_pkg::DIST_W-1:0] acc_reg, acc_next;
    logic [fnpt_pkg::DIST_W-1:0] best_d_reg, best_d_next;

    fnpt_pkg::entry_t           rdata;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    fnpt_pkg::entry_t           ram_wdata;

    logic                       slot_free;
    logic                       accept;
    logic                       scan_done;
    logic                       grp_ok;
    logic signed [23:0]         sq_a, sq_b;
    logic [fnpt_pkg::DIST_W-1:0] dist_sum;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign grp_ok    = (rdata.group == 16'd0) || (rdata.group == q_reg.group);
    assign scan_done = (i_reg >= held_reg) ||
                       ((mode_reg == fnpt_pkg::MODE_LIST) && (n_reg == MAX_OUT_C));
    assign dist_sum  = acc_reg + fnpt_pkg::DIST_W'(prod_reg);

    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                sq_a = rdata.x;
                sq_b = q_reg.x;
            end
            2'd1:
            begin
                sq_a = rdata.y;
                sq_b = q_reg.y;
            end
            default:
            begin
                sq_a = rdata.z;
                sq_b = q_reg.z;
            end
        endcase
    end

    fnpt_ram #(
        .WIDTH (fnpt_pkg::ENTRY_W),
        .DEPTH (fnpt_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        i_next          = i_reg;
        w_next          = w_reg;
        n_next          = n_reg;
        phase_next      = phase_reg;
        hit_next        = hit_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_d_next     = best_d_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_status_next = out_status_reg;
        out_ent_next    = out_ent_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = w_reg[IDX_W-1:0];
        ram_wdata       = rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    i_next          = '0;
                    w_next          = '0;
                    n_next          = '0;
                    phase_next      = '0;
                    hit_next        = 1'b0;
                    best_valid_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (mode == fnpt_pkg::MODE_UPSERT || mode == fnpt_pkg::MODE_REMOVE ||
                        mode == fnpt_pkg::MODE_GET || mode == fnpt_pkg::MODE_NEAREST ||
                        mode == fnpt_pkg::MODE_LIST)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_RD:
            begin
                if (scan_done)
                begin
                    if (mode_reg == fnpt_pkg::MODE_NEAREST && best_valid_reg)
                    begin
                        i_next     = best_idx_reg;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                case (mode_reg)
                    fnpt_pkg::MODE_UPSERT:
                    begin
                        if (rdata.id == q_reg.id)
                        begin
                            hit_next      = 1'b1;
                            best_idx_next = i_reg;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    fnpt_pkg::MODE_REMOVE:
                    begin
                        if (rdata.id == q_reg.id)
                        begin
                            hit_next = 1'b1;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                            w_next = w_reg + CNT_W'(1);
                        end
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                    fnpt_pkg::MODE_GET:
                    begin
                        if (rdata.id == q_reg.id)
                        begin
                            if (slot_free)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = fnpt_pkg::ST_OK;
                                out_ent_next    = rdata;
                                out_cnt_next    = fnpt_pkg::sat_count(held_reg);
                                out_last_next   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    fnpt_pkg::MODE_NEAREST:
                    begin
                        if (rdata.map == q_reg.map && grp_ok)
                        begin
                            phase_next = '0;
                            state_next = S_SQ;
                        end
                        else
                        begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    fnpt_pkg::MODE_LIST:
                    begin
                        if (rdata.map == q_reg.map)
                        begin
                            if (!pend_valid_reg || slot_free)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = fnpt_pkg::ST_OK;
                                    out_ent_next    = pend_reg;
                                    out_cnt_next    = fnpt_pkg::sat_count(held_reg);
                                    out_last_next   = 1'b0;
                                end
                                pend_next       = rdata;
                                pend_valid_next = 1'b1;
                                n_next          = n_reg + LIST_W'(1);
                                i_next          = i_reg + CNT_W'(1);
                                state_next      = S_RD;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SQ:
            begin
                prod_next  = fnpt_pkg::sq_diff(sq_a, sq_b);
                acc_next   = (phase_reg == 2'd0) ? '0 : dist_sum;
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    if (!best_valid_reg || dist_sum < best_d_reg)
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = i_reg;
                        best_d_next     = dist_sum;
                    end
                    phase_next = '0;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_RD;
                end
            end
            S_FETCH:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fnpt_pkg::ST_NOTFOUND;
                    out_ent_next    = '0;
                    out_cnt_next    = fnpt_pkg::sat_count(held_reg);
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    case (mode_reg)
                        fnpt_pkg::MODE_UPSERT:
                        begin
                            if (hit_reg)
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = best_idx_reg[IDX_W-1:0];
                                ram_wdata       = q_reg;
                                out_status_next = fnpt_pkg::ST_OK;
                                out_ent_next    = q_reg;
                            end
                            else if (held_reg >= DEPTH_C)
                            begin
                                out_status_next = fnpt_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_waddr       = held_reg[IDX_W-1:0];
                                ram_wdata       = q_reg;
                                held_next       = held_reg + CNT_W'(1);
                                out_status_next = fnpt_pkg::ST_OK;
                                out_ent_next    = q_reg;
                                out_cnt_next    = fnpt_pkg::sat_count(held_reg + CNT_W'(1));
                            end
                        end
                        fnpt_pkg::MODE_REMOVE:
                        begin
                            held_next       = w_reg;
                            out_cnt_next    = fnpt_pkg::sat_count(w_reg);
                            out_status_next = hit_reg ? fnpt_pkg::ST_OK : fnpt_pkg::ST_NOTFOUND;
                        end
                        fnpt_pkg::MODE_NEAREST:
                        begin
                            if (best_valid_reg)
                            begin
                                out_status_next = fnpt_pkg::ST_OK;
                                out_ent_next    = rdata;
                            end
                        end
                        fnpt_pkg::MODE_COUNT:
                        begin
                            out_status_next = fnpt_pkg::ST_OK;
                        end
                        fnpt_pkg::MODE_LIST:
                        begin
                            if (pend_valid_reg)
                            begin
                                out_status_next = fnpt_pkg::ST_OK;
                                out_ent_next    = pend_reg;
                            end
                        end
                        default:
                        begin
                            out_status_next = fnpt_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_reg       <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            n_reg          <= '0;
            phase_reg      <= '0;
            hit_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
            best_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= fnpt_pkg::ST_OK;
            out_ent_reg    <= '0;
            out_cnt_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            i_reg          <= i_next;
            w_reg          <= w_next;
            n_reg          <= n_next;
            phase_reg      <= phase_next;
            hit_reg        <= hit_next;
            best_valid_reg <= best_valid_next;
            best_idx_reg   <= best_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_ent_reg    <= out_ent_next;
            out_cnt_reg    <= out_cnt_next;
            out_last_reg   <= out_last_next;
        end
    end

    // request capture and datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            q_reg.id    <= point_id;
            q_reg.map   <= map_key;
            q_reg.group <= group_key;
            q_reg.x     <= coord_x;
            q_reg.y     <= coord_y;
            q_reg.z     <= coord_z;
        end
        pend_reg   <= pend_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        best_d_reg <= best_d_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_id    = out_ent_reg.id;
    assign found_map   = out_ent_reg.map;
    assign found_group = out_ent_reg.group;
    assign found_x     = out_ent_reg.x;
    assign found_y     = out_ent_reg.y;
    assign found_z     = out_ent_reg.z;
    assign entry_count = out_cnt_reg;
    assign last        = out_last_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= DEPTH_C)
        else $error("held count above table depth");

    a_held_change: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |-> ($past(state_reg) == S_FIN))
        else $error("held count changed outside final step");

    a_best_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        best_valid_reg |-> (best_idx_reg < held_reg))
        else $error("nearest candidate outside table");

    a_compact_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && mode_reg == fnpt_pkg::MODE_REMOVE && ram_we)
        |-> (w_reg <= i_reg))
        else $error("remove compaction writes ahead of read");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam fnpt_pkg::mode_code_t MODE_SPARE_A = 3'd6;
    localparam fnpt_pkg::mode_code_t MODE_SPARE_B = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam logic signed [23:0] C_MAX = 24'sh7fffff;
    localparam logic signed [23:0] C_MIN = -24'sh800000;

    typedef struct {
        fnpt_pkg::status_t  status;
        logic [31:0]        id;
        logic [15:0]        map;
        logic [15:0]        group;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [5:0]         count;
        logic               last;
    } point_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [2:0]         mode = '0;
    logic [31:0]        point_id = '0;
    logic [15:0]        map_key = '0;
    logic [15:0]        group_key = '0;
    logic signed [23:0] coord_x = '0;
    logic signed [23:0] coord_y = '0;
    logic signed [23:0] coord_z = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    fnpt_pkg::status_t  status;
    logic [31:0]        found_id;
    logic [15:0]        found_map;
    logic [15:0]        found_group;
    logic signed [23:0] found_x;
    logic signed [23:0] found_y;
    logic signed [23:0] found_z;
    logic [5:0]         entry_count;
    logic               last;

    // predictor copy of the table
    logic [31:0]        tbl_id [fnpt_pkg::TABLE_DEPTH];
    logic [15:0]        tbl_map [fnpt_pkg::TABLE_DEPTH];
    logic [15:0]        tbl_group [fnpt_pkg::TABLE_DEPTH];
    logic signed [23:0] tbl_x [fnpt_pkg::TABLE_DEPTH];
    logic signed [23:0] tbl_y [fnpt_pkg::TABLE_DEPTH];
    logic signed [23:0] tbl_z [fnpt_pkg::TABLE_DEPTH];
    int                 tbl_count = 0;

    point_result_t      pending_results[$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 rsp_stall_pct = 0;
    int                 quiet_cycles = 0;

    filtered_nearest_point_table_top dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("filtered_nearest_point_table_top regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        point_result_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result id", found_id, '0);
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status) report_mismatch("status", status, e.status);
                if (found_id !== e.id) report_mismatch("found_id", found_id, e.id);
                if (found_map !== e.map) report_mismatch("found_map", found_map, e.map);
                if (found_group !== e.group)
                    report_mismatch("found_group", found_group, e.group);
                if (found_x !== e.x) report_mismatch("found_x", found_x, e.x);
                if (found_y !== e.y) report_mismatch("found_y", found_y, e.y);
                if (found_z !== e.z) report_mismatch("found_z", found_z, e.z);
                if (entry_count !== e.count)
                    report_mismatch("entry_count", entry_count, e.count);
                if (last !== e.last) report_mismatch("last", last, e.last);
            end
        end
    end

    function automatic void push_result(input fnpt_pkg::status_t st, input int idx,
                                        input logic lst);
        point_result_t r;
        r = '{st, '0, '0, '0, '0, '0, '0, '0, lst};
        if (idx >= 0)
        begin
            r.id = tbl_id[idx];
            r.map = tbl_map[idx];
            r.group = tbl_group[idx];
            r.x = tbl_x[idx];
            r.y = tbl_y[idx];
            r.z = tbl_z[idx];
        end
        r.count = (tbl_count > 63) ? 6'd63 : 6'(tbl_count);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic longint unsigned axis_sq(input logic signed [23:0] a,
                                                input logic signed [23:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    function automatic int lookup_id(input logic [31:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void predict_item(input fnpt_pkg::mode_code_t md,
                                         input logic [31:0] id,
                                         input logic [15:0] mp, input logic [15:0] gp,
                                         input logic signed [23:0] x,
                                         input logic signed [23:0] y,
                                         input logic signed [23:0] z);
        int idx;
        int w;
        int n;
        int best;
        bit hit;
        longint unsigned d;
        longint unsigned best_d;
        case (md)
            fnpt_pkg::MODE_UPSERT:
            begin
                idx = lookup_id(id);
                if (idx < 0 && tbl_count >= fnpt_pkg::TABLE_DEPTH)
                    push_result(fnpt_pkg::ST_FULL, -1, 1'b1);
                else
                begin
                    if (idx < 0)
                    begin
                        idx = tbl_count;
                        tbl_count++;
                    end
                    tbl_id[idx] = id;
                    tbl_map[idx] = mp;
                    tbl_group[idx] = gp;
                    tbl_x[idx] = x;
                    tbl_y[idx] = y;
                    tbl_z[idx] = z;
                    push_result(fnpt_pkg::ST_OK, idx, 1'b1);
                end
            end
            fnpt_pkg::MODE_REMOVE:
            begin
                w = 0;
                hit = 1'b0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_id[i] == id)
                        hit = 1'b1;
                    else
                    begin
                        tbl_id[w] = tbl_id[i];
                        tbl_map[w] = tbl_map[i];
                        tbl_group[w] = tbl_group[i];
                        tbl_x[w] = tbl_x[i];
                        tbl_y[w] = tbl_y[i];
                        tbl_z[w] = tbl_z[i];
                        w++;
                    end
                end
                tbl_count = w;
                push_result(hit ? fnpt_pkg::ST_OK : fnpt_pkg::ST_NOTFOUND, -1, 1'b1);
            end
            fnpt_pkg::MODE_GET:
            begin
                idx = lookup_id(id);
                push_result(idx < 0 ? fnpt_pkg::ST_NOTFOUND : fnpt_pkg::ST_OK, idx, 1'b1);
            end
            fnpt_pkg::MODE_NEAREST:
            begin
                best = -1;
                best_d = 0;
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_map[i] == mp && (tbl_group[i] == 16'd0 || tbl_group[i] == gp))
                    begin
                        d = axis_sq(tbl_x[i], x) + axis_sq(tbl_y[i], y)
                            + axis_sq(tbl_z[i], z);
                        if (best < 0 || d < best_d)
                        begin
                            best = i;
                            best_d = d;
                        end
                    end
                end
                push_result(best < 0 ? fnpt_pkg::ST_NOTFOUND : fnpt_pkg::ST_OK, best, 1'b1);
            end
            fnpt_pkg::MODE_COUNT:
                push_result(fnpt_pkg::ST_OK, -1, 1'b1);
            fnpt_pkg::MODE_LIST:
            begin
                n = 0;
                for (int i = 0; i < tbl_count && n < fnpt_pkg::MAX_OUT; i++)
                begin
                    if (tbl_map[i] == mp)
                    begin
                        push_result(fnpt_pkg::ST_OK, i, 1'b0);
                        n++;
                    end
                end
                if (n == 0)
                    push_result(fnpt_pkg::ST_NOTFOUND, -1, 1'b1);
                else
                    pending_results[$].last = 1'b1;
            end
            default:
                push_result(fnpt_pkg::ST_NOTFOUND, -1, 1'b1);
        endcase
    endfunction

    task automatic send_item(input fnpt_pkg::mode_code_t md, input logic [31:0] id,
                             input logic [15:0] mp, input logic [15:0] gp,
                             input logic signed [23:0] x, input logic signed [23:0] y,
                             input logic signed [23:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        mode <= md;
        point_id <= id;
        map_key <= mp;
        group_key <= gp;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        do
            @(posedge clk);
        while (!req_ready);
        predict_item(md, id, mp, gp, x, y, z);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_item(fnpt_pkg::MODE_COUNT, '0, '0, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_LIST, '0, 16'h0001, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_GET, 32'h1234, '0, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_NEAREST, '0, '0, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_REMOVE, 32'h1234, '0, '0, '0, '0, '0);
        send_item(MODE_SPARE_A, '1, '1, '1, C_MIN, C_MIN, C_MIN);
        send_item(MODE_SPARE_B, '0, '0, '0, C_MAX, C_MAX, C_MAX);
    endtask

    task automatic test_extremes();
        send_item(fnpt_pkg::MODE_UPSERT, 32'h0, 16'hffff, 16'hffff, C_MAX, C_MIN, C_MAX);
        send_item(fnpt_pkg::MODE_UPSERT, 32'hffffffff, 16'hffff, 16'h0, C_MIN, C_MAX, C_MIN);
        send_item(fnpt_pkg::MODE_NEAREST, '0, 16'hffff, 16'h0001, C_MAX, C_MAX, C_MAX);
        send_item(fnpt_pkg::MODE_NEAREST, '0, 16'hffff, 16'hffff, C_MIN, C_MIN, C_MIN);
        send_item(fnpt_pkg::MODE_UPSERT, 32'h0, 16'hffff, 16'h0, 24'sd5, -24'sd5, 24'sd0);
        send_item(fnpt_pkg::MODE_GET, 32'h0, '0, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_LIST, '0, 16'hffff, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_REMOVE, 32'hffffffff, '0, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_REMOVE, 32'h0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_nearest_rules();
        // equal distances: earliest entry wins, group mismatch skipped
        send_item(fnpt_pkg::MODE_UPSERT, 32'd10, 16'd7, 16'd3, 24'sd100, '0, '0);
        send_item(fnpt_pkg::MODE_UPSERT, 32'd11, 16'd7, 16'd0, -24'sd100, '0, '0);
        send_item(fnpt_pkg::MODE_UPSERT, 32'd12, 16'd7, 16'd4, 24'sd1, '0, '0);
        send_item(fnpt_pkg::MODE_UPSERT, 32'd13, 16'd8, 16'd0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_NEAREST, '0, 16'd7, 16'd3, '0, '0, '0);
        send_item(fnpt_pkg::MODE_NEAREST, '0, 16'd7, 16'd5, '0, '0, '0);
        send_item(fnpt_pkg::MODE_NEAREST, '0, 16'd7, 16'd4, '0, '0, '0);
        send_item(fnpt_pkg::MODE_LIST, '0, 16'd7, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_REMOVE, 32'd11, '0, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_LIST, '0, 16'd7, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_COUNT, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_full_table();
        while (tbl_count < fnpt_pkg::TABLE_DEPTH)
            send_item(fnpt_pkg::MODE_UPSERT, $urandom, 16'd9, 16'($urandom_range(1)),
                      24'($urandom), 24'($urandom), 24'($urandom));
        send_item(fnpt_pkg::MODE_UPSERT, 32'hdead0001, 16'd9, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_LIST, '0, 16'd9, '0, '0, '0, '0);
        send_item(fnpt_pkg::MODE_UPSERT, tbl_id[5], 16'd9, 16'd0, C_MAX, C_MAX, C_MAX);
        send_item(fnpt_pkg::MODE_NEAREST, '0, 16'd9, 16'd0, C_MAX, C_MAX, C_MAX);
        wait_drained();
        while (tbl_count > 0)
            send_item(fnpt_pkg::MODE_REMOVE, tbl_id[$urandom_range(tbl_count - 1)],
                      '0, '0, '0, '0, '0);
    endtask

    task automatic test_random(input int n);
        int pick;
        fnpt_pkg::mode_code_t md;
        logic [31:0] id;
        logic [15:0] mp;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 38) md = fnpt_pkg::MODE_UPSERT;
            else if (pick < 52) md = fnpt_pkg::MODE_REMOVE;
            else if (pick < 64) md = fnpt_pkg::MODE_GET;
            else if (pick < 80) md = fnpt_pkg::MODE_NEAREST;
            else if (pick < 85) md = fnpt_pkg::MODE_COUNT;
            else if (pick < 95) md = fnpt_pkg::MODE_LIST;
            else md = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
            id = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(1, 40));
            mp = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            send_item(md, id, mp, 16'($urandom_range(2)), 24'($urandom), 24'($urandom),
                      24'($urandom));
            if (k == n / 2 && send_idle_pct == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_extremes();
        test_nearest_rules();
        test_full_table();
        test_random(40);
        send_idle_pct = 87;
        test_random(40);
        send_idle_pct = 0;
        rsp_stall_pct = 87;
        test_random(40);
        send_idle_pct = 25;
        rsp_stall_pct = 25;
        test_random(40);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("filtered_nearest_point_table_top regression: pass");
        else
            $display("filtered_nearest_point_table_top regression: fail");
        $finish;
    end

endmodule
